### rtl/core/mtt_pkg.sv
package mtt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_EXPIRE     = 16;
  localparam int INDEX_W        = 4;
  localparam int TICK_W         = 32;
  localparam int DATA_W         = 8;
  localparam int QUEUE_W        = 3;

  localparam logic [TICK_W-1:0] NO_DEADLINE = '1;

  typedef enum logic [2:0] {
    K_TICK  = 3'd0,
    K_ALLOC = 3'd1,
    K_FREE  = 3'd2,
    K_SET   = 3'd3,
    K_ARM   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    RES_DONE   = 2'd0,
    RES_GRANT  = 2'd1,
    RES_FAIL   = 2'd2,
    RES_EXPIRY = 2'd3
  } result_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [TICK_W-1:0]   deadline;
    logic [DATA_W-1:0]   data;
    logic [QUEUE_W-1:0]  queue;
  } entry_t;

  typedef struct packed {
    logic                free;
    logic                set;
    logic                arm;
    logic [DATA_W-1:0]   data;
    logic [QUEUE_W-1:0]  queue;
    logic [TICK_W-1:0]   deadline;
  } cell_cmd_t;

endpackage

### rtl/core/mtt_in_if.sv
interface mtt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  timer_index;
  logic [31:0] delay;
  logic [7:0]  data_byte;
  logic [2:0]  queue_id;

  modport source (output valid, kind, timer_index, delay, data_byte, queue_id, input ready);
  modport sink (input valid, kind, timer_index, delay, data_byte, queue_id, output ready);
endinterface

### rtl/core/mtt_out_if.sv
interface mtt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [3:0] out_index;
  logic [7:0] out_data;
  logic [2:0] out_queue;
  logic       last;

  modport source (output valid, result_kind, out_index, out_data, out_queue, last, input ready);
  modport sink (input valid, result_kind, out_index, out_data, out_queue, last, output ready);
endinterface

### rtl/core/mtt_cell.sv
module mtt_cell
  import mtt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  entry_t    shift_in,
  input  cell_cmd_t cmd,
  output entry_t    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.status <= ST_FREE;
    end else if (shift) begin
      q <= shift_in;
    end else begin
      if (cmd.arm) begin
        q.status   <= ST_RUN;
        q.deadline <= cmd.deadline;
      end else if (cmd.free) begin
        q.status <= ST_FREE;
      end
      if (cmd.set) begin
        q.data  <= cmd.data;
        q.queue <= cmd.queue;
      end
    end
  end

endmodule

### rtl/core/multi_timer_table_unit.sv
// Channel  Direction  Content
// req      in         kind, timer_index, delay, data_byte, queue_id
// rsp      out        result_kind, out_index, out_data, out_queue, last
//
// Free, set data, arm and a tick that is not yet due are answered with a single done item.
// Allocate and a due tick rotate the row of entry cells once past the head
// and then issue the final item.
// Reset clears the tick count and every entry's status and sets the next-due time to NO_DEADLINE.
// A stalled rsp holds the rotation whenever a further expiry item is waiting.
module multi_timer_table_unit
  import mtt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input logic        clk,
  input logic        rst,
  mtt_in_if.sink     req,
  mtt_out_if.source  rsp
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(MAX_EXPIRE + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t               state;
  logic                 alloc_mode;
  logic [IW-1:0]        step;
  logic [CW-1:0]        n_exp;
  logic [TICK_W-1:0]    tick_count;
  logic [TICK_W-1:0]    next_due;
  logic                 held_valid;
  logic [INDEX_W-1:0]   held_index;
  logic [DATA_W-1:0]    held_data;
  logic [QUEUE_W-1:0]   held_queue;
  logic                 out_valid;
  result_t              out_kind;
  logic [INDEX_W-1:0]   out_index;
  logic [DATA_W-1:0]    out_data;
  logic [QUEUE_W-1:0]   out_queue;
  logic                 out_last;

  entry_t               cell_q  [NUM_TIMERS];
  entry_t               head;
  entry_t               head_new;
  logic                 slot_free;
  logic                 accept;
  logic [TICK_W-1:0]    tick_next;
  logic [TICK_W-1:0]    arm_deadline;
  logic                 idx_ok;
  logic                 is_tick;
  logic                 is_alloc;
  logic                 starts_scan;
  logic                 expire;
  logic                 take;
  logic                 push;
  logic                 adv;
  logic                 step_last;
  cell_cmd_t            cmd_all;

  assign slot_free    = !out_valid || rsp.ready;
  assign req.ready    = (state == S_IDLE) && slot_free;
  assign accept       = req.valid && req.ready;
  assign tick_next    = tick_count + TICK_W'(1);
  assign arm_deadline = req.delay + tick_count;
  assign idx_ok       = int'(req.timer_index) < NUM_TIMERS;
  assign is_tick      = kind_t'(req.kind) == K_TICK;
  assign is_alloc     = kind_t'(req.kind) == K_ALLOC;
  assign starts_scan  = is_alloc || (is_tick && !(next_due > tick_next));

  assign head      = cell_q[0];
  assign expire    = !alloc_mode && head.status == ST_RUN && head.deadline <= tick_count
                     && n_exp < CW'(MAX_EXPIRE);
  assign take      = alloc_mode && head.status == ST_FREE && !held_valid;
  assign push      = expire && held_valid;
  assign adv       = (state == S_SCAN) && (!push || slot_free);
  assign step_last = step == IW'(NUM_TIMERS - 1);

  always_comb begin
    head_new = head;
    if (expire || take) begin
      head_new.status = ST_ALLOC;
    end
  end

  always_comb begin
    cmd_all.free     = accept && idx_ok && kind_t'(req.kind) == K_FREE;
    cmd_all.set      = accept && idx_ok && kind_t'(req.kind) == K_SET;
    cmd_all.arm      = accept && idx_ok && kind_t'(req.kind) == K_ARM;
    cmd_all.data     = req.data_byte;
    cmd_all.queue    = req.queue_id;
    cmd_all.deadline = arm_deadline;
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    entry_t    sin;
    cell_cmd_t cmd;
    logic      sel;

    assign sel = int'(req.timer_index) == i;

    always_comb begin
      cmd      = cmd_all;
      cmd.free = cmd_all.free && sel;
      cmd.set  = cmd_all.set && sel;
      cmd.arm  = cmd_all.arm && sel;
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign sin = head_new;
    end else begin : g_body
      assign sin = cell_q[i + 1];
    end

    mtt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (adv),
      .shift_in (sin),
      .cmd      (cmd),
      .q        (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      alloc_mode <= 1'b0;
      step       <= '0;
      n_exp      <= '0;
      tick_count <= '0;
      next_due   <= NO_DEADLINE;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_valid  <= !starts_scan;
            out_kind   <= RES_DONE;
            out_index  <= '0;
            out_data   <= '0;
            out_queue  <= '0;
            out_last   <= 1'b1;
            alloc_mode <= is_alloc;
            step       <= '0;
            n_exp      <= '0;
            held_valid <= 1'b0;
            if (starts_scan) begin
              state <= S_SCAN;
            end
            if (is_tick) begin
              tick_count <= tick_next;
              if (starts_scan) begin
                next_due <= NO_DEADLINE;
              end
            end
            if (cmd_all.arm && next_due > arm_deadline) begin
              next_due <= arm_deadline;
            end
          end
        end
        S_SCAN: begin
          if (adv) begin
            step <= step + IW'(1);
            if (step_last) begin
              state <= S_FLUSH;
            end
            if (expire) begin
              n_exp      <= n_exp + CW'(1);
              held_valid <= 1'b1;
              held_index <= INDEX_W'(step);
              held_data  <= head.data;
              held_queue <= head.queue;
              if (held_valid) begin
                out_valid <= 1'b1;
                out_kind  <= RES_EXPIRY;
                out_index <= held_index;
                out_data  <= held_data;
                out_queue <= held_queue;
                out_last  <= 1'b0;
              end
            end else if (!alloc_mode && head.status == ST_RUN && next_due > head.deadline) begin
              next_due <= head.deadline;
            end
            if (take) begin
              held_valid <= 1'b1;
              held_index <= INDEX_W'(step);
            end
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            out_index <= '0;
            out_data  <= '0;
            out_queue <= '0;
            if (alloc_mode) begin
              out_kind <= held_valid ? RES_GRANT : RES_FAIL;
              if (held_valid) begin
                out_index <= held_index;
              end
            end else if (held_valid) begin
              out_kind  <= RES_EXPIRY;
              out_index <= held_index;
              out_data  <= held_data;
              out_queue <= held_queue;
            end else begin
              out_kind <= RES_DONE;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.out_index   = out_index;
  assign rsp.out_data    = out_data;
  assign rsp.out_queue   = out_queue;
  assign rsp.last        = out_last;

  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && adv && !step_last) |=> state == S_SCAN)
    else $error("rotation left before passing every entry");

  a_flush_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && slot_free) |=> (state == S_IDLE && out_valid && out_last))
    else $error("final item not issued at end of rotation");

  a_alloc_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == RES_GRANT || out_kind == RES_FAIL)) |-> out_last)
    else $error("allocation result not marked last");

  a_no_expiry_in_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && alloc_mode) |-> !expire && !push)
    else $error("expiry raised during an allocation pass");

endmodule
